### rtl/core/rtsmac_pkg.sv
// ----------------------------------------------------------------------------
// RTS/CTS MAC package
// Shared types and codes of the channel-handshake MAC engine.
// ----------------------------------------------------------------------------
package rtsmac_pkg;

  localparam int ADDR_BITS_DEF    = 8;
  localparam int CHANNEL_BITS_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int TIMER_BITS       = 24;
  localparam int MAX_RESULTS      = 4;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [3:0] OP_APP      = 4'd0;
  localparam logic [3:0] OP_FRAME    = 4'd1;
  localparam logic [3:0] OP_FREE     = 4'd2;
  localparam logic [3:0] OP_DATA     = 4'd3;
  localparam logic [3:0] OP_PROPOSED = 4'd4;
  localparam logic [3:0] OP_DYNAMIC  = 4'd5;
  localparam logic [3:0] OP_PU       = 4'd6;
  localparam logic [3:0] OP_DYN_UPD  = 4'd7;
  localparam logic [3:0] OP_TICK     = 4'd8;

  localparam logic [2:0] FK_RTS       = 3'd0;
  localparam logic [2:0] FK_CTS       = 3'd1;
  localparam logic [2:0] FK_DATA      = 3'd2;
  localparam logic [2:0] FK_ACK       = 3'd3;
  localparam logic [2:0] FK_RTS_NACK  = 3'd4;
  localparam logic [2:0] FK_DATA_NACK = 3'd5;
  localparam logic [2:0] FK_EOT       = 3'd6;

  localparam logic [1:0] PORT_RADIO  = 2'd0;
  localparam logic [1:0] PORT_SENSE  = 2'd1;
  localparam logic [1:0] PORT_STATUS = 2'd2;

  localparam logic [1:0] SK_FREE     = 2'd0;
  localparam logic [1:0] SK_DATA     = 2'd1;
  localparam logic [1:0] SK_PROPOSED = 2'd2;
  localparam logic [1:0] SK_DYNAMIC  = 2'd3;

  localparam logic [2:0] REG_OWN_ADDR  = 3'd0;
  localparam logic [2:0] REG_DYN_EN    = 3'd1;
  localparam logic [2:0] REG_ACK_EN    = 3'd2;
  localparam logic [2:0] REG_FRAMES    = 3'd3;
  localparam logic [2:0] REG_ATTEMPTS  = 3'd4;
  localparam logic [2:0] REG_SENSE_PP  = 3'd5;
  localparam logic [2:0] REG_RTS_TO    = 3'd6;
  localparam logic [2:0] REG_ACK_TO    = 3'd7;

  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  frame_kind;
    logic [7:0]  frame_source;
    logic [7:0]  frame_destination;
    logic [3:0]  frame_channel;
    logic [15:0] frame_count;
    logic [7:0]  app_destination;
    logic [3:0]  reply_channel;
    logic        channel_free;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_port;
    logic [2:0]  tx_kind;
    logic [7:0]  tx_source;
    logic [7:0]  tx_destination;
    logic [3:0]  tx_channel;
    logic [15:0] tx_count;
    logic [1:0]  sense_kind;
    logic [3:0]  sense_channel_id;
    logic        status_success;
    logic        last;
  } out_item_t;

  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] res;
    logic [2:0]                  count;
  } batch_t;

  typedef struct packed {
    logic [7:0]  own_address;
    logic        dynamic_channel_enable;
    logic        ack_enable;
    logic [15:0] frames_per_session;
    logic [3:0]  rts_attempt_limit;
    logic        sense_per_packet;
    logic [23:0] rts_timeout_ticks;
    logic [23:0] ack_timeout_ticks;
  } cfg_t;

endpackage

### rtl/core/rts_cts_channel_handshake_mac_top.sv
// Path: an event's result batch is registered in the engine, then in a queue slot.
// Throughput: one event per cycle while in_stall is low; an event with n results
// yields n result transfers, so the rate is bounded by one result per cycle.
// Reset: synchronous rst restores register defaults and the MAC state and
// empties the result queue.
// ----------------------------------------------------------------------------
// RTS/CTS channel-handshake MAC top
// Configuration registers, event engine and result queue.
// ----------------------------------------------------------------------------
module rts_cts_channel_handshake_mac_top
  import rtsmac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  batch_t push_batch;
  logic   full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address            <= 8'd1;
      cfg.dynamic_channel_enable <= 1'b0;
      cfg.ack_enable             <= 1'b1;
      cfg.frames_per_session     <= 16'd10;
      cfg.rts_attempt_limit      <= 4'd3;
      cfg.sense_per_packet       <= 1'b0;
      cfg.rts_timeout_ticks      <= 24'd300;
      cfg.ack_timeout_ticks      <= 24'd120;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OWN_ADDR: cfg.own_address            <= cfg_data[7:0];
        REG_DYN_EN:   cfg.dynamic_channel_enable <= cfg_data[0];
        REG_ACK_EN:   cfg.ack_enable             <= cfg_data[0];
        REG_FRAMES:   cfg.frames_per_session     <= cfg_data[15:0];
        REG_ATTEMPTS: cfg.rts_attempt_limit      <= cfg_data[3:0];
        REG_SENSE_PP: cfg.sense_per_packet       <= cfg_data[0];
        REG_RTS_TO:   cfg.rts_timeout_ticks      <= cfg_data[23:0];
        REG_ACK_TO:   cfg.ack_timeout_ticks      <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  rtsmac_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_item    (in_data),
    .in_stall   (in_stall),
    .push       (push),
    .push_batch (push_batch),
    .queue_full (full)
  );

  rtsmac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_batch (push_batch),
    .full       (full),
    .out_valid  (out_valid),
    .out_item   (out_data),
    .out_stall  (out_stall)
  );

endmodule

### rtl/core/rtsmac_engine.sv
// ----------------------------------------------------------------------------
// RTS/CTS MAC engine
// Accepts one event a cycle unless the result queue is full, updates the MAC state
// and pushes the batch of results that the event causes into the result queue.
// ----------------------------------------------------------------------------
module rtsmac_engine
  import rtsmac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  output logic     push,
  output batch_t   push_batch,
  input  logic     queue_full
);

  logic [15:0] frames_left, frames_left_next;
  logic [3:0]  attempts_left, attempts_left_next;
  logic [7:0]  peer_destination, peer_destination_next;
  logic [3:0]  data_channel, data_channel_next;
  logic [3:0]  offered_channel, offered_channel_next;
  logic [7:0]  cts_peer, cts_peer_next;
  logic [3:0]  dynamic_channel, dynamic_channel_next;
  logic        receiving_flag, receiving_flag_next;
  logic        transmitting_flag, transmitting_flag_next;
  logic        rts_pending_flag, rts_pending_flag_next;
  logic [23:0] rts_countdown, rts_countdown_next;
  logic [23:0] ack_countdown, ack_countdown_next;
  batch_t      b;
  logic        fire;

  assign in_stall = queue_full;
  assign fire     = in_valid && !queue_full;

  function automatic out_item_t mk_frame(logic [2:0] k, logic [7:0] s, logic [7:0] d,
                                         logic [3:0] c, logic [15:0] n);
    out_item_t r;
    r = '0;
    r.out_port = PORT_RADIO;
    r.tx_kind = k;
    r.tx_source = s;
    r.tx_destination = d;
    r.tx_channel = c;
    r.tx_count = n;
    return r;
  endfunction

  function automatic out_item_t mk_sense(logic [1:0] k, logic [3:0] c);
    out_item_t r;
    r = '0;
    r.out_port = PORT_SENSE;
    r.sense_kind = k;
    r.sense_channel_id = c;
    return r;
  endfunction

  function automatic out_item_t mk_status(logic ok);
    out_item_t r;
    r = '0;
    r.out_port = PORT_STATUS;
    r.status_success = ok;
    return r;
  endfunction

  function automatic logic [23:0] load_of(logic [23:0] t);
    return (t == '0) ? 24'd1 : t;
  endfunction

  always_comb begin
    logic        rts_fire;
    logic        ack_fire;
    logic        run_send_data;
    out_item_t   item;
    frames_left_next       = frames_left;
    attempts_left_next     = attempts_left;
    peer_destination_next  = peer_destination;
    data_channel_next      = data_channel;
    offered_channel_next   = offered_channel;
    cts_peer_next          = cts_peer;
    dynamic_channel_next   = dynamic_channel;
    receiving_flag_next    = receiving_flag;
    transmitting_flag_next = transmitting_flag;
    rts_pending_flag_next  = rts_pending_flag;
    rts_countdown_next     = rts_countdown;
    ack_countdown_next     = ack_countdown;
    b                      = '0;
    rts_fire               = 1'b0;
    ack_fire               = 1'b0;
    run_send_data          = 1'b0;
    item                   = '0;

    case (in_item.op)
      OP_APP: begin
        if (!(receiving_flag || rts_pending_flag || transmitting_flag)) begin
          peer_destination_next = in_item.app_destination;
          frames_left_next      = cfg.frames_per_session;
          attempts_left_next    = cfg.rts_attempt_limit;
          if (cfg.dynamic_channel_enable) b.res[0] = mk_sense(SK_DYNAMIC, dynamic_channel);
          else b.res[0] = mk_sense(SK_FREE, '0);
          b.count = 3'd1;
        end
      end
      OP_FRAME: begin
        if (in_item.frame_destination == cfg.own_address) begin
          case (in_item.frame_kind)
            FK_RTS: begin
              if (!(receiving_flag && in_item.frame_source != cts_peer) &&
                  !transmitting_flag) begin
                receiving_flag_next   = 1'b1;
                rts_pending_flag_next = 1'b0;
                offered_channel_next  = in_item.frame_channel;
                cts_peer_next         = in_item.frame_source;
                b.res[0] = mk_sense(SK_PROPOSED, in_item.frame_channel);
                b.count  = 3'd1;
              end
            end
            FK_CTS: begin
              rts_countdown_next = '0;
              if (data_channel != '0 && in_item.frame_channel == data_channel) begin
                rts_pending_flag_next  = 1'b0;
                transmitting_flag_next = 1'b1;
                run_send_data          = 1'b1;
              end else begin
                attempts_left_next = cfg.rts_attempt_limit;
                b.res[0] = mk_sense(SK_FREE, '0);
                b.count  = 3'd1;
              end
            end
            FK_DATA: begin
              if (cfg.ack_enable && data_channel != '0) begin
                receiving_flag_next = 1'b1;
                b.res[0] = mk_frame(FK_ACK, cfg.own_address, in_item.frame_source,
                                    in_item.frame_channel, in_item.frame_count);
                b.count  = 3'd1;
              end
            end
            FK_ACK: begin
              ack_countdown_next = '0;
              frames_left_next   = frames_left - 16'd1;
              if (frames_left_next != '0) begin
                if (data_channel != '0) begin
                  if (cfg.sense_per_packet) begin
                    b.res[0] = mk_sense(SK_DATA, data_channel);
                    b.count  = 3'd1;
                  end else begin
                    run_send_data = 1'b1;
                  end
                end
              end else begin
                b.res[0] = mk_frame(FK_EOT, cfg.own_address, peer_destination,
                                    data_channel, '0);
                b.res[1] = mk_status(1'b1);
                b.count  = 3'd2;
                rts_countdown_next = '0; ack_countdown_next = '0;
                attempts_left_next = '0; data_channel_next = '0;
                receiving_flag_next = 1'b0; transmitting_flag_next = 1'b0;
                rts_pending_flag_next = 1'b0;
              end
            end
            FK_RTS_NACK, FK_DATA_NACK: begin
              if (transmitting_flag) begin
                rts_pending_flag_next  = 1'b0;
                transmitting_flag_next = 1'b0;
                if (in_item.frame_kind == FK_RTS_NACK) begin
                  attempts_left_next = cfg.rts_attempt_limit;
                  rts_countdown_next = '0;
                end else begin
                  ack_countdown_next = '0;
                end
                b.res[0] = mk_sense(SK_FREE, '0);
                b.count  = 3'd1;
              end else if (receiving_flag) begin
                rts_countdown_next = '0; ack_countdown_next = '0;
                attempts_left_next = '0; data_channel_next = '0;
                receiving_flag_next = 1'b0; transmitting_flag_next = 1'b0;
                rts_pending_flag_next = 1'b0;
              end
            end
            FK_EOT: begin
              rts_countdown_next = '0; ack_countdown_next = '0;
              attempts_left_next = '0; data_channel_next = '0;
              receiving_flag_next = 1'b0; transmitting_flag_next = 1'b0;
              rts_pending_flag_next = 1'b0;
              b.res[0] = mk_frame(FK_EOT, '0, '0, '0, '0);
              b.count  = 3'd1;
            end
            default: begin
            end
          endcase
        end
      end
      OP_FREE, OP_DYNAMIC: begin
        if (in_item.op == OP_FREE && in_item.reply_channel == '0) begin
          transmitting_flag_next = 1'b0;
          rts_pending_flag_next  = 1'b0;
          b.res[0] = mk_status(1'b0);
          b.count  = 3'd1;
        end else if (in_item.op == OP_DYNAMIC && !in_item.channel_free) begin
          b.res[0] = mk_sense(SK_FREE, '0);
          b.count  = 3'd1;
        end else if (in_item.op == OP_FREE || !receiving_flag) begin
          item = '0;
          data_channel_next = (in_item.op == OP_FREE) ? in_item.reply_channel
                                                      : dynamic_channel;
          if (attempts_left != '0) begin
            b.res[0] = mk_frame(FK_RTS, cfg.own_address, peer_destination,
                                data_channel_next, '0);
            b.count  = 3'd1;
            attempts_left_next    = attempts_left - 4'd1;
            rts_pending_flag_next = 1'b1;
            if (rts_countdown == '0) rts_countdown_next = load_of(cfg.rts_timeout_ticks);
          end else begin
            rts_countdown_next = '0; ack_countdown_next = '0;
            attempts_left_next = '0; data_channel_next = '0;
            receiving_flag_next = 1'b0; transmitting_flag_next = 1'b0;
            rts_pending_flag_next = 1'b0;
            b.res[0] = mk_status(1'b0);
            b.count  = 3'd1;
          end
        end
      end
      OP_DATA: begin
        run_send_data = in_item.channel_free;
      end
      OP_PROPOSED: begin
        if (in_item.channel_free) begin
          data_channel_next = offered_channel;
          b.res[0] = mk_frame(FK_CTS, cfg.own_address, cts_peer, offered_channel, '0);
        end else begin
          receiving_flag_next = 1'b0;
          b.res[0] = mk_frame(FK_RTS_NACK, '0, cts_peer, '0, '0);
        end
        b.count = 3'd1;
      end
      OP_PU: begin
        if (transmitting_flag) begin
          if (cfg.ack_enable) ack_countdown_next = '0;
          data_channel_next  = '0;
          attempts_left_next = cfg.rts_attempt_limit;
          if (!rts_pending_flag) begin
            if (cfg.dynamic_channel_enable) b.res[0] = mk_sense(SK_DYNAMIC, dynamic_channel);
            else b.res[0] = mk_sense(SK_FREE, '0);
            b.count = 3'd1;
          end
        end else begin
          if (receiving_flag) begin
            b.res[0] = mk_frame(FK_DATA_NACK, '0, cts_peer, '0, '0);
            b.count  = 3'd1;
          end
          rts_countdown_next = '0; ack_countdown_next = '0;
          attempts_left_next = '0; data_channel_next = '0;
          receiving_flag_next = 1'b0; transmitting_flag_next = 1'b0;
          rts_pending_flag_next = 1'b0;
        end
      end
      OP_DYN_UPD: begin
        dynamic_channel_next = in_item.frame_channel;
      end
      OP_TICK: begin
        if (rts_countdown != '0) begin
          rts_countdown_next = rts_countdown - 24'd1;
          rts_fire = (rts_countdown == 24'd1);
        end
        if (ack_countdown != '0) begin
          ack_countdown_next = ack_countdown - 24'd1;
          ack_fire = (ack_countdown == 24'd1);
        end
        if (rts_fire) begin
          if (attempts_left != '0) begin
            b.res[0] = mk_sense(SK_FREE, '0);
          end else begin
            rts_pending_flag_next = 1'b0;
            b.res[0] = mk_status(1'b0);
          end
          b.count = 3'd1;
        end
        run_send_data = ack_fire;
      end
      default: begin
      end
    endcase

    if (run_send_data && cfg.ack_enable) begin
      if (data_channel_next != '0) begin
        item = mk_frame(FK_DATA, cfg.own_address, peer_destination, data_channel_next,
                        frames_left_next);
        b.res[b.count[1:0]] = item;
        b.count = b.count + 3'd1;
        rts_pending_flag_next = 1'b0;
        if (ack_countdown_next == '0) ack_countdown_next = load_of(cfg.ack_timeout_ticks);
      end else begin
        rts_countdown_next = '0; ack_countdown_next = '0;
        attempts_left_next = '0; data_channel_next = '0;
        receiving_flag_next = 1'b0; transmitting_flag_next = 1'b0;
        rts_pending_flag_next = 1'b0;
      end
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      b.res[i].last = (3'(i) + 3'd1 == b.count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_left       <= '0;
      peer_destination  <= '0;
      data_channel      <= '0;
      offered_channel   <= '0;
      cts_peer          <= '0;
      dynamic_channel   <= 4'd1;
      receiving_flag    <= 1'b0;
      transmitting_flag <= 1'b0;
      rts_pending_flag  <= 1'b0;
      rts_countdown     <= '0;
      ack_countdown     <= '0;
      attempts_left     <= 4'd3;
      push              <= 1'b0;
    end else begin
      push <= fire && (b.count != '0);
      if (fire) begin
        frames_left       <= frames_left_next;
        attempts_left     <= attempts_left_next;
        peer_destination  <= peer_destination_next;
        data_channel      <= data_channel_next;
        offered_channel   <= offered_channel_next;
        cts_peer          <= cts_peer_next;
        dynamic_channel   <= dynamic_channel_next;
        receiving_flag    <= receiving_flag_next;
        transmitting_flag <= transmitting_flag_next;
        rts_pending_flag  <= rts_pending_flag_next;
        rts_countdown     <= rts_countdown_next;
        ack_countdown     <= ack_countdown_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    push_batch <= b;
  end

endmodule

### rtl/core/rtsmac_queue.sv
// ----------------------------------------------------------------------------
// RTS/CTS MAC result queue
// Holds result batches and unrolls each into single result transfers.
// ----------------------------------------------------------------------------
module rtsmac_queue
  import rtsmac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  batch_t    push_batch,
  output logic      full,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  batch_t    slots [QUEUE_DEPTH];
  logic      wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic [1:0] pos;
  logic      pop_item, pop_batch;

  // one slot kept spare for the batch in flight in the engine's register
  assign full      = (fill >= 2'(QUEUE_DEPTH - 1)) && !(pop_batch && fill == 2'd1);
  assign out_valid = (fill != '0);
  assign out_item  = slots[rd_ptr].res[pos];
  assign pop_item  = out_valid && !out_stall;
  assign pop_batch = pop_item && out_item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
      pos    <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop_batch) begin
        rd_ptr <= !rd_ptr;
        pos    <= '0;
      end else if (pop_item) begin
        pos <= pos + 2'd1;
      end
      fill <= fill + 2'(push) - 2'(pop_batch);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_batch;
  end

endmodule
